>>> rtl/core/fadd_pkg.sv
// fadd_pkg: shared types and constants for the fraction adder.
// Holds the sequencer state type and the fixed output field widths.
// No dependencies.
package fadd_pkg;

  localparam int NUM_W      = 33;
  localparam int DEN_W      = 32;
  localparam int OUT_BITS   = 2 * NUM_W + 2 * DEN_W;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AD,
    S_MUL_CB,
    S_MUL_BD,
    S_ABS_N,
    S_ABS_D,
    S_GCD,
    S_GSH,
    S_PREP,
    S_DIV,
    S_FIX,
    S_FINISH
  } state_t;

endpackage

>>> rtl/core/fraction_add_reduce.sv
// fraction_add_reduce: adds two signed fractions and reduces the sum by its gcd.
// One shared multiplier and one shared add/subtract unit under a sequencer.
// Depends on fadd_pkg.
//
// Usage:
//   Slave channel s_*: one transaction carries num_a, den_a, num_b, den_b.
//   Master channel m_*: one transaction per input with the unreduced sum
//   (raw_num, raw_den), the reduced sum (red_num, red_den) and in m_tuser
//   the bad_den flag. A zero input denominator gives bad_den = 1 and all
//   data fields zero.
//   Work: the three products and the two magnitudes, then a binary gcd loop
//   with a shift back for each shared power of two, then two restoring
//   divisions of AW bits with AW = min(2*DATA_WIDTH+1, 64). The sum, the
//   magnitudes, the gcd and the divisions share the one add/subtract unit.
//   s_tready is high only while the sequencer is idle; one item is in work
//   at a time.
//   The result sits in an output register, so a new item is accepted while
//   the previous result still waits for m_tready; a finished item waits in
//   its last step until that register is free.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   m_tvalid; any item in work is lost.
module fraction_add_reduce #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // num_a, den_a, num_b, den_b (DATA_WIDTH each), zero padding
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // raw_num[33], raw_den[32], red_num[33], red_den[32], zero padding
  output logic [fadd_pkg::M_TDATA_W-1:0]        m_tdata,
  // bad_den
  output logic                                  m_tuser
);

  import fadd_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = (2 * DW + 1 > 64) ? 64 : 2 * DW + 1;
  localparam int KW = $clog2(AW);
  localparam int PAD_W = M_TDATA_W - OUT_BITS;

  state_t state, state_next;

  logic signed [DW-1:0]   a, b, c, d;
  logic signed [2*DW-1:0] p;
  logic signed [AW-1:0]   sn, sd;
  logic signed [AW-1:0]   red_num, red_den;
  logic [AW-1:0]          x, y, g, q, r;
  logic [KW-1:0]          k, cnt;
  logic                   neg, sel, bad;

  logic signed [DW-1:0]   mul_x, mul_y;
  logic signed [2*DW-1:0] mul_p;
  logic [AW:0]            alu_a, alu_b, alu_res;
  logic                   alu_sub;
  logic signed [AW-1:0]   div_src;
  logic [AW-1:0]          rs;
  logic                   in_bad, out_free, load_out;

  assign in_bad   = (s_tdata[2*DW-1:DW] == '0) || (s_tdata[4*DW-1:3*DW] == '0);
  assign out_free = !m_tvalid || m_tready;
  assign div_src  = sel ? sd : sn;
  assign rs       = {r[AW-2:0], q[AW-1]};
  assign mul_p    = mul_x * mul_y;
  assign alu_res  = alu_a + (alu_sub ? ~alu_b : alu_b) + {{AW{1'b0}}, alu_sub};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    mul_x      = a;
    mul_y      = d;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b1;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = in_bad ? S_FINISH : S_MUL_AD;
        end
      end
      S_MUL_AD: begin
        state_next = S_MUL_CB;
      end
      S_MUL_CB: begin
        mul_x      = c;
        mul_y      = b;
        state_next = S_MUL_BD;
      end
      S_MUL_BD: begin
        mul_x      = b;
        mul_y      = d;
        alu_a      = (AW+1)'(sn);
        alu_b      = (AW+1)'(p);
        alu_sub    = 1'b0;
        state_next = S_ABS_N;
      end
      S_ABS_N: begin
        alu_b      = (AW+1)'(sn);
        state_next = S_ABS_D;
      end
      S_ABS_D: begin
        alu_b      = (AW+1)'(sd);
        state_next = S_GCD;
      end
      S_GCD: begin
        alu_a = {1'b0, x};
        alu_b = {1'b0, y};
        if (x == '0 || y == '0) begin
          state_next = S_GSH;
        end
      end
      S_GSH: begin
        if (k == '0) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        alu_b      = (AW+1)'(div_src);
        state_next = S_DIV;
      end
      S_DIV: begin
        alu_a = {1'b0, rs};
        alu_b = {1'b0, g};
        if (cnt == '0) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        alu_b      = {1'b0, q};
        state_next = sel ? S_FINISH : S_PREP;
      end
      S_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath, stepped by the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a   <= s_tdata[DW-1:0];
        b   <= s_tdata[2*DW-1:DW];
        c   <= s_tdata[3*DW-1:2*DW];
        d   <= s_tdata[4*DW-1:3*DW];
        sel <= 1'b0;
        k   <= '0;
        bad <= in_bad;
        if (in_bad) begin
          sn      <= '0;
          sd      <= '0;
          red_num <= '0;
          red_den <= '0;
        end
      end
      S_MUL_AD: begin
        p <= mul_p;
      end
      S_MUL_CB: begin
        sn <= AW'(p);
        p  <= mul_p;
      end
      S_MUL_BD: begin
        sn <= alu_res[AW-1:0];
        p  <= mul_p;
      end
      S_ABS_N: begin
        sd <= AW'(p);
        x  <= sn[AW-1] ? alu_res[AW-1:0] : sn;
      end
      S_ABS_D: begin
        y <= sd[AW-1] ? alu_res[AW-1:0] : sd;
      end
      S_GCD: begin
        // binary gcd, one step per cycle; k counts shared factors of two
        if (x == '0 || y == '0) begin
          g <= x | y;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (!alu_res[AW]) begin
          x <= alu_res[AW-1:0] >> 1;
        end else begin
          x <= y;
          y <= x;
        end
      end
      S_GSH: begin
        if (k != '0) begin
          g <= {g[AW-2:0], 1'b0};
          k <= k - 1'b1;
        end
      end
      S_PREP: begin
        neg <= div_src[AW-1];
        q   <= div_src[AW-1] ? alu_res[AW-1:0] : div_src;
        r   <= '0;
        cnt <= KW'(AW - 1);
      end
      S_DIV: begin
        if (!alu_res[AW]) begin
          r <= alu_res[AW-1:0];
          q <= {q[AW-2:0], 1'b1};
        end else begin
          r <= rs;
          q <= {q[AW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      S_FIX: begin
        if (sel) begin
          red_den <= neg ? alu_res[AW-1:0] : q;
        end else begin
          red_num <= neg ? alu_res[AW-1:0] : q;
          sel     <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{PAD_W{1'b0}}, DEN_W'(red_den), NUM_W'(red_num),
                  DEN_W'(sd), NUM_W'(sn)};
      m_tuser <= bad;
    end
  end

  // remainder stays below the divisor throughout the division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> r < g)
    else $error("division remainder not below divisor");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP || state == S_DIV || state == S_FIX) |-> g != '0)
    else $error("gcd is zero during division");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad denominator result carries nonzero data");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[OUT_BITS-1:2*NUM_W+DEN_W] != '0)
    else $error("reduced denominator is zero");

  a_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_free |=> m_tvalid && state == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

>>> dv/fraction_add_reduce_chk.sv
// fraction_add_reduce_chk: watches both stream channels of the fraction adder,
// predicts each output transaction on input and compares it with the actual one.
// Depends on fadd_pkg for the output field and bus widths.
module fraction_add_reduce_chk #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // num_a, den_a, num_b, den_b (DATA_WIDTH each), zero padding
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // raw_num[33], raw_den[32], red_num[33], red_den[32], zero padding
  input  logic [fadd_pkg::M_TDATA_W-1:0]    m_tdata,
  // bad_den
  input  logic                              m_tuser,
  output int                                errors,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = fadd_pkg::NUM_W;
  localparam int DW = fadd_pkg::DEN_W;

  typedef struct {
    logic [NW-1:0] raw_num;
    logic [DW-1:0] raw_den;
    logic [NW-1:0] red_num;
    logic [DW-1:0] red_den;
    logic          bad_den;
  } frac_sum_t;

  frac_sum_t sums_due[$];

  function automatic logic [63:0] widen(input logic [DATA_WIDTH-1:0] v);
    return {{(64-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // g divides v exactly; the quotient keeps the sign of v
  function automatic logic [63:0] div_keep_sign(input logic [63:0] v, input logic [63:0] g);
    logic [63:0] q;
    q = magnitude(v) / g;
    return v[63] ? (64'd0 - q) : q;
  endfunction

  function automatic frac_sum_t sum_fractions(input logic [4*DATA_WIDTH-1:0] item);
    logic [63:0] na, da, nb, db, sn, sd, x, y, t;
    frac_sum_t r;
    na = widen(item[0*DATA_WIDTH +: DATA_WIDTH]);
    da = widen(item[1*DATA_WIDTH +: DATA_WIDTH]);
    nb = widen(item[2*DATA_WIDTH +: DATA_WIDTH]);
    db = widen(item[3*DATA_WIDTH +: DATA_WIDTH]);
    r = '{default: '0};
    if (da == 64'd0 || db == 64'd0) begin
      r.bad_den = 1'b1;
      return r;
    end
    sn = na * db + nb * da;
    sd = da * db;
    // Euclid on magnitudes; a zero numerator leaves |sd|
    x = magnitude(sd);
    y = magnitude(sn);
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 64'd0) x = 64'd1;
    r.raw_num = sn[NW-1:0];
    r.raw_den = sd[DW-1:0];
    r.red_num = NW'(div_keep_sign(sn, x));
    r.red_den = DW'(div_keep_sign(sd, x));
    return r;
  endfunction

  task automatic check_field(input string name, input logic [NW-1:0] want,
                             input logic [NW-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    frac_sum_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (sums_due.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h user %b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = sums_due.pop_front();
          check_field("raw_num", want.raw_num, m_tdata[0 +: NW]);
          check_field("raw_den", NW'(want.raw_den), NW'(m_tdata[NW +: DW]));
          check_field("red_num", want.red_num, m_tdata[NW+DW +: NW]);
          check_field("red_den", NW'(want.red_den), NW'(m_tdata[2*NW+DW +: DW]));
          check_field("bad_den", NW'(want.bad_den), NW'(m_tuser));
        end
      end
      if (s_tvalid && s_tready)
        sums_due.push_back(sum_fractions(s_tdata[4*DATA_WIDTH-1:0]));
    end
    pending <= sums_due.size();
  end

endmodule

>>> dv/fraction_add_reduce_tb.sv
// fraction_add_reduce_tb: drives directed and random fraction pairs into the
// fraction adder with random idling on both channels and gives the verdict.
// Depends on fadd_pkg, fraction_add_reduce and fraction_add_reduce_chk.
module fraction_add_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = 16;
  localparam int IN_W       = ((4*DATA_WIDTH+7)/8)*8;
  localparam int N_RANDOM   = 600;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [IN_W-1:0]                s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [fadd_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tuser;
  logic                           calm = 1'b0;
  int                             errors;
  int                             pending;

  always #5 clk = ~clk;

  fraction_add_reduce #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fraction_add_reduce_chk #(.DATA_WIDTH(DATA_WIDTH)) chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // output side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_pair(input logic [15:0] na, input logic [15:0] da,
                           input logic [15:0] nb, input logic [15:0] db);
    int gap;
    if (!calm) begin
      if ($urandom_range(19) == 0) begin
        gap = $urandom_range(250, 1);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while ($urandom_range(99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {db, nb, da, na};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] small_val();
    return 16'($signed($urandom_range(30)) - 15);
  endfunction

  function automatic logic [15:0] corner_val();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'h0001;
    endcase
  endfunction

  initial begin
    logic [15:0] na, da, nb, db, k;
    int kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(16'd1, 16'd2, 16'd1, 16'd3);
    // numerator sum cancels
    send_pair(16'd1, 16'd2, -16'sd1, 16'd2);
    send_pair(16'd0, 16'd5, 16'd0, -16'sd7);
    // zero denominators
    send_pair(16'd3, 16'd0, 16'd1, 16'd2);
    send_pair(16'd1, 16'd2, 16'd3, 16'd0);
    send_pair(16'd0, 16'd0, 16'd0, 16'd0);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_pair(16'h8000, 16'd1, 16'h8000, 16'd1);
    send_pair(16'h7fff, 16'd1, 16'h7fff, 16'd1);
    send_pair(16'd1, 16'h8000, 16'd1, 16'h8000);
    send_pair(16'd3, 16'd6, 16'd1, 16'd6);
    send_pair(-16'sd5, -16'sd10, 16'd7, 16'd14);
    send_pair(16'd12, 16'd8, -16'sd4, -16'sd16);
    send_pair(-16'sd1, -16'sd1, -16'sd1, 16'd1);
    send_pair(16'd0, 16'h8000, 16'd5, 16'h8000);
    send_pair(16'd1, 16'h7fff, 16'd1, -16'sd1);
    send_pair(16'd1024, 16'd4096, 16'd2048, 16'd8192);
    send_pair(-16'sd1, 16'd3, 16'd1, 16'd6);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 250) calm <= 1'b1;
      if (i == 350) calm <= 1'b0;
      if (i == 450) drain();
      kind = $urandom_range(99);
      if (kind < 50) begin
        na = 16'($urandom()); da = 16'($urandom());
        nb = 16'($urandom()); db = 16'($urandom());
      end else if (kind < 68) begin
        na = small_val(); da = small_val(); nb = small_val(); db = small_val();
      end else if (kind < 78) begin
        // opposite fractions over one denominator
        na = 16'($urandom()); da = 16'($urandom());
        nb = -na; db = da;
      end else if (kind < 90) begin
        // shared factor so the reduction does real work
        k  = 16'($urandom_range(255, 1));
        na = small_val() * k; da = small_val() * k;
        nb = small_val() * k; db = small_val() * k;
      end else begin
        na = corner_val(); da = corner_val(); nb = corner_val(); db = corner_val();
      end
      send_pair(na, da, nb, db);
    end
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("[fraction_add_reduce] OK");
    end else begin
      $display("[fraction_add_reduce] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[fraction_add_reduce] ERROR");
    $finish;
  end

endmodule
